@@ hdl/count_min_sketch_engine_unit_macros.svh @@
// Assertion macros for the count-min sketch engine checker.
// Included by the checker file only.
`ifndef COUNT_MIN_SKETCH_ENGINE_UNIT_MACROS_SVH
`define COUNT_MIN_SKETCH_ENGINE_UNIT_MACROS_SVH
// implication checked on every clock, disabled in reset
`define CMS_ASSERT_IMP(label, clk, rst_n, lhs, rhs, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
        else $error(msg);
// next-cycle implication, disabled in reset
`define CMS_ASSERT_NXT(label, clk, rst_n, lhs, rhs, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
        else $error(msg);
`endif

@@ hdl/cms_pkg.sv @@
// Package for the count-min sketch engine: constants, payload and control types.
// Used by cms_ctrl, cms_data and the top level; depends on nothing.
package cms_pkg;
    localparam int ROWS_DEF    = 3;
    localparam int BUCKETS_DEF = 1024;
    localparam longint PRIME_DEF = 2147483647;
    localparam int HASH_REGS   = 3;
    localparam int CFG_COUNT   = 7;

    localparam logic OP_UPDATE = 1'b0;
    localparam logic OP_QUERY  = 1'b1;

    localparam logic [2:0] REG_BUCKETS = 3'd6;

    typedef struct packed {
        logic               opcode;
        logic [31:0]        item_key;
        logic signed [31:0] weight;
    } t_in;

    typedef struct packed {
        logic signed [63:0] estimate;
        logic signed [63:0] weight_total;
    } t_out;

    // controller to datapath commands
    typedef struct packed {
        logic       load;     // capture item, start hashing
        logic       hash_go;  // start hash of selected row
        logic [1:0] row;
        logic       rd;       // read counter of row
        logic       wr;       // write back updated counter
        logic       clr;      // clear pass write
        logic       fin;      // finish item: total update / result
    } t_cmd;

    typedef struct packed {
        logic hash_done;
        logic clr_last;
    } t_sts;
endpackage

@@ hdl/cms_ctrl.sv @@
// Controller state machine of the count-min sketch engine.
// Depends on cms_pkg; drives the datapath by command structs.
module cms_ctrl #(
    parameter int ROWS = cms_pkg::ROWS_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    output logic           o_busy,
    output cms_pkg::t_cmd  o_cmd,
    input  cms_pkg::t_sts  i_sts
);
    typedef enum logic [5:0] {
        S_CLR  = 6'b000001,
        S_IDLE = 6'b000010,
        S_HASH = 6'b000100,
        S_RD   = 6'b001000,
        S_WR   = 6'b010000,
        S_FIN  = 6'b100000
    } t_state;

    t_state r_state, n_state;
    logic [1:0] r_row, n_row;

    // advance state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_row   <= '0;
        end else begin
            r_state <= n_state;
            r_row   <= n_row;
        end
    end

    // next state and commands
    always_comb begin
        n_state = r_state;
        n_row   = r_row;
        o_cmd   = '0;
        o_cmd.row = r_row;
        unique case (r_state)
            S_CLR: begin
                o_cmd.clr = 1'b1;
                if (i_sts.clr_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_row   = '0;
                    n_state = S_HASH;
                end
            end
            S_HASH: begin
                if (i_sts.hash_done) n_state = S_RD;
            end
            S_RD: begin
                o_cmd.rd = 1'b1;
                n_state  = S_WR;
            end
            S_WR: begin
                o_cmd.wr = 1'b1;
                if (r_row == 2'(ROWS - 1)) begin
                    n_state = S_FIN;
                end else begin
                    n_row = r_row + 2'd1;
                    o_cmd.hash_go = 1'b1;
                    o_cmd.row = r_row + 2'd1;
                    n_state = S_HASH;
                end
            end
            S_FIN: begin
                o_cmd.fin = 1'b1;
                n_state   = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_busy = (r_state != S_IDLE);
endmodule

@@ hdl/cms_data.sv @@
// Datapath of the count-min sketch engine: hash, bucket reduction, counter memory.
// Depends on cms_pkg; commanded by cms_ctrl.
module cms_data #(
    parameter int     ROWS    = cms_pkg::ROWS_DEF,
    parameter int     BUCKETS = cms_pkg::BUCKETS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  cms_pkg::t_in  i_in,
    input  cms_pkg::t_cmd i_cmd,
    output cms_pkg::t_sts o_sts,
    input  logic [30:0]   i_mult [cms_pkg::HASH_REGS],
    input  logic [30:0]   i_add  [cms_pkg::HASH_REGS],
    input  logic [10:0]   i_bcnt,
    output logic          o_valid,
    output cms_pkg::t_out o_out
);
    localparam int BW   = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam int AW   = $clog2(ROWS * BUCKETS);
    localparam int DEP  = ROWS * BUCKETS;
    localparam int NW   = $clog2(BUCKETS + 1);
    localparam int HW   = 64;
    // hash value bits for a remainder below the prime
    localparam int PW   = 31;

    // item hold
    cms_pkg::t_in r_item;
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) r_item <= i_in;
    end

    // buckets in use
    logic [NW-1:0] w_nb;
    always_comb begin
        if (i_bcnt == 11'd0) w_nb = NW'(1);
        else if ({21'd0, i_bcnt} > 32'(BUCKETS)) w_nb = NW'(BUCKETS);
        else w_nb = NW'(i_bcnt);
    end

    // hash: multiply, two folds by the Mersenne prime 2^31-1, then a
    // shift-subtract remainder by the bucket count, one bit a cycle
    typedef enum logic [4:0] {
        H_IDLE = 5'b00001, H_MUL = 5'b00010, H_FOLD = 5'b00100,
        H_MODP = 5'b01000, H_MODN = 5'b10000
    } t_hs;
    t_hs r_hs;
    logic [HW-1:0] r_val;
    logic [PW:0]   r_rem;
    logic [4:0]    r_cnt;
    logic [1:0]    r_hrow;
    logic          r_done;
    logic [32:0]   w_fold;
    logic [31:0]   w_hp;
    logic [PW:0]   w_rn;

    // fold high part onto low part, then one conditional subtract
    always_comb begin
        w_fold = 33'(r_val[63:31]) + 33'(r_val[30:0]);
        if (w_fold >= 33'(cms_pkg::PRIME_DEF)) w_hp = 32'(w_fold - 33'(cms_pkg::PRIME_DEF));
        else w_hp = 32'(w_fold);
        w_rn = {r_rem[PW-1:0], r_val[HW-1]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hs   <= H_IDLE;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_hs)
                H_IDLE: begin
                    if (i_cmd.load || i_cmd.hash_go) begin
                        r_hrow <= i_cmd.load ? 2'd0 : i_cmd.row;
                        r_hs   <= H_MUL;
                    end
                end
                H_MUL: begin
                    r_val <= 64'(i_mult[r_hrow]) * 64'(r_item.item_key)
                             + 64'(i_add[r_hrow]);
                    r_hs  <= H_FOLD;
                end
                H_FOLD: begin
                    r_val <= 64'(w_fold);
                    r_hs  <= H_MODP;
                end
                H_MODP: begin
                    r_val <= {w_hp, 32'd0};
                    r_rem <= '0;
                    r_cnt <= 5'd0;
                    r_hs  <= H_MODN;
                end
                H_MODN: begin
                    r_val <= {r_val[HW-2:0], 1'b0};
                    if (w_rn >= (PW+1)'(w_nb)) r_rem <= w_rn - (PW+1)'(w_nb);
                    else r_rem <= w_rn;
                    r_cnt <= r_cnt + 5'd1;
                    if (r_cnt == 5'd31) begin
                        r_hs   <= H_IDLE;
                        r_done <= 1'b1;
                    end
                end
                default: r_hs <= H_IDLE;
            endcase
        end
    end
    assign o_sts.hash_done = r_done;

    // counter memory with clear pass
    logic [63:0] r_mem [DEP];
    logic [AW-1:0] r_clra;
    logic [AW-1:0] w_addr;
    logic [63:0] r_rd;
    assign w_addr = AW'(r_hrow * BUCKETS) + AW'(r_rem[BW-1:0]);
    assign o_sts.clr_last = (r_clra == AW'(DEP - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_clra <= '0;
        else if (i_cmd.clr) r_clra <= r_clra + AW'(1);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.clr) r_mem[r_clra] <= 64'd0;
        else if (i_cmd.wr && r_item.opcode == cms_pkg::OP_UPDATE)
            r_mem[w_addr] <= r_rd + 64'(r_item.weight);
        if (i_cmd.rd) r_rd <= r_mem[w_addr];
    end

    // running minimum and total
    logic signed [63:0] r_min, r_tot;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tot   <= '0;
            o_valid <= 1'b0;
        end else begin
            o_valid <= 1'b0;
            if (i_cmd.load) r_min <= 64'sh7FFF_FFFF_FFFF_FFFF;
            if (i_cmd.wr && $signed(r_rd) < r_min) r_min <= $signed(r_rd);
            if (i_cmd.fin) begin
                if (r_item.opcode == cms_pkg::OP_UPDATE)
                    r_tot <= r_tot + 64'(r_item.weight);
                else begin
                    o_valid <= 1'b1;
                    o_out.estimate     <= r_min;
                    o_out.weight_total <= r_tot;
                end
            end
        end
    end
endmodule

@@ hdl/count_min_sketch_engine_unit.sv @@
// Top level of the count-min sketch engine.
// Depends on cms_pkg, cms_ctrl and cms_data.
//
// Usage: drive i_item and raise start while busy is low; the item is
// transferred at that edge. Opcode update adds weight to one counter per
// row and to the total; opcode query returns one result on o_result,
// marked by o_result_valid for one cycle, holding the minimum counter
// over rows and the running total. Updates return nothing.
// Each row takes one multiply, two folds by the prime, a bit-serial
// remainder by bucket_count (32 steps), a handshake, then a memory read
// and a write. A query result shows in the cycle where busy falls; no new
// item is accepted until the last one is through.
// Reset clears the hash registers and the total, sets bucket_count to
// 1024 and starts a clearing pass over the counter memory with busy high;
// APB writes work throughout.
// The receiver cannot stall: results are shown for one cycle only.
// The user must write configuration over APB only while the block is idle; the block itself does not enforce it.
module count_min_sketch_engine_unit #(
    parameter int     ROWS    = cms_pkg::ROWS_DEF,
    parameter int     BUCKETS = cms_pkg::BUCKETS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    input  cms_pkg::t_in  i_item,
    output logic          o_result_valid,
    output cms_pkg::t_out o_result,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [4:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready
);
    logic [30:0] r_mult [cms_pkg::HASH_REGS];
    logic [30:0] r_add  [cms_pkg::HASH_REGS];
    logic [10:0] r_bcnt;
    logic [2:0]  w_idx;
    cms_pkg::t_cmd w_cmd;
    cms_pkg::t_sts w_sts;

    assign pready = 1'b1;
    assign w_idx  = paddr[4:2];

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < cms_pkg::HASH_REGS; k++) begin
                r_mult[k] <= '0;
                r_add[k]  <= '0;
            end
            r_bcnt <= 11'd1024;
        end else if (psel && penable && pwrite) begin
            if (w_idx == cms_pkg::REG_BUCKETS) r_bcnt <= pwdata[10:0];
            else if (w_idx < cms_pkg::REG_BUCKETS) begin
                if (w_idx[0]) r_add[w_idx[2:1]]  <= pwdata[30:0];
                else          r_mult[w_idx[2:1]] <= pwdata[30:0];
            end
        end
    end

    // register reads
    always_comb begin
        prdata = '0;
        if (w_idx == cms_pkg::REG_BUCKETS) prdata = {21'd0, r_bcnt};
        else if (w_idx < cms_pkg::REG_BUCKETS) begin
            if (w_idx[0]) prdata = {1'b0, r_add[w_idx[2:1]]};
            else          prdata = {1'b0, r_mult[w_idx[2:1]]};
        end
    end

    cms_ctrl #(.ROWS(ROWS)) u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(start), .o_busy(busy),
        .o_cmd(w_cmd), .i_sts(w_sts)
    );

    cms_data #(.ROWS(ROWS), .BUCKETS(BUCKETS)) u_data (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in(i_item), .i_cmd(w_cmd),
        .o_sts(w_sts), .i_mult(r_mult), .i_add(r_add), .i_bcnt(r_bcnt),
        .o_valid(o_result_valid), .o_out(o_result)
    );
endmodule

@@ hdl/cms_checker.sv @@
// Port-level checker for the count-min sketch engine, bound to the top level.
// Depends on the macros header.
`include "count_min_sketch_engine_unit_macros.svh"
module cms_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic start,
    input logic busy,
    input logic o_result_valid,
    input logic pready
);
    `CMS_ASSERT_NXT(a_acc_busy, i_clk, i_rst_n, start && !busy, busy, "busy not raised")
    `CMS_ASSERT_IMP(a_res_busy, i_clk, i_rst_n, o_result_valid, !busy, "result while busy")
    `CMS_ASSERT_NXT(a_res_one, i_clk, i_rst_n, o_result_valid, !o_result_valid, "double result")
    `CMS_ASSERT_IMP(a_ready, i_clk, i_rst_n, 1'b1, pready, "pready low")
endmodule

bind count_min_sketch_engine_unit cms_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
    .o_result_valid(o_result_valid), .pready(pready)
);
